// ----- sv/flc_pkg.sv -----
// Shared types, constants and helpers for the fan level controller.
package flc_pkg;

    // Fixed thresholds and delays
    localparam logic [15:0] INIT_HIGH_AMBIENT = 16'd820;
    localparam logic [15:0] INIT_MID_AMBIENT  = 16'd700;
    localparam logic [31:0] DWELL_MS          = 32'd3000;
    localparam logic [31:0] OFF_DELAY_MS      = 32'd5000;

    // Item packing on the stream ports
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned OUT_TDATA_W = 16;

    // Step commands carried in tuser
    typedef enum logic [1:0] {
        CMD_AUTO     = 2'd0,
        CMD_LOWPOWER = 2'd1,
        CMD_MANUAL   = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    // Fan state reported with each item
    typedef enum logic [1:0] {
        FAN_INIT  = 2'd0,
        FAN_RUN   = 2'd1,
        FAN_STOP  = 2'd2,
        FAN_ERROR = 2'd3
    } fan_state_t;

    // Outlet temperature zones of the run state
    typedef enum logic [1:0] {
        ZONE_UP   = 2'd0,
        ZONE_HOLD = 2'd1,
        ZONE_DOWN = 2'd2
    } zone_t;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_INCREASE_TEMP  = 3'd0,
        REG_DECREASE_TEMP  = 3'd1,
        REG_LOW_DUTY       = 3'd2,
        REG_MIDDLE_DUTY    = 3'd3,
        REG_HIGH_DUTY      = 3'd4,
        REG_CHANGE_INTERVAL = 3'd5,
        REG_REFERENCE_TEMP = 3'd6,
        REG_DEADBAND       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] increase_temp;
        logic [15:0] decrease_temp;
        logic [7:0]  low_duty;
        logic [7:0]  middle_duty;
        logic [7:0]  high_duty;
        logic [15:0] change_interval_ms;
        logic [15:0] reference_temp;
        logic [14:0] deadband;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  manual_level;
        logic [1:0]  fan_state;
        logic [15:0] measured_temp;
        logic [15:0] outlet_temp;
        logic [15:0] ambient_temp;
        logic [31:0] now_ms;
        logic [1:0]  cmd;
    } item_t;

    typedef struct packed {
        logic       level_changed;
        logic       power_on;
        logic [7:0] pwm_duty;
        logic [1:0] fan_level;
    } result_t;

    // Duty for a fan level, zero for level 0
    function automatic logic [7:0] duty_of(input logic [1:0] lvl, input cfg_t c);
        logic [7:0] d;
        case (lvl)
            2'd1:    d = c.low_duty;
            2'd2:    d = c.middle_duty;
            2'd3:    d = c.high_duty;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/fan_level_controller.sv -----
// Fan level controller top level: input register, step logic, result register.
//
// One input item is one control step and gives one result item. An item sits
// in the input register, the step logic works on it and the result register
// takes the outcome; m_tvalid rises once the result register is loaded, which
// can wait while the result side stalls. The block accepts one item every cycle
// while the result side keeps up. The state update of a step and the result
// register load on the same edge, so the next item always sees the state left
// by the previous one. The user must write configuration registers over the
// APB port only while no item is in flight; the block does not enforce this.
// The duty for a level is latched when that level is driven.
module fan_level_controller
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms[31:0], ambient_temp[47:32], outlet_temp[63:48],
    // measured_temp[79:64], fan_state[81:80], manual_level[83:82], zero pad
    input  logic [flc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // cmd[1:0]
    input  logic [1:0]                        s_tuser,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fan_level[1:0], pwm_duty[9:2], power_on[10], level_changed[11], zero pad
    output logic [flc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import flc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    // Step fires when an item waits and the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= {s_tdata[83:0], s_tuser};
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    flc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    flc_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

endmodule

// ----- sv/flc_cfg.sv -----
// Configuration register file behind the APB-style port.
module flc_cfg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output flc_pkg::cfg_t cfg
);
    import flc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_INCREASE_TEMP:   cfg_reg.increase_temp      <= pwdata[15:0];
                REG_DECREASE_TEMP:   cfg_reg.decrease_temp      <= pwdata[15:0];
                REG_LOW_DUTY:        cfg_reg.low_duty           <= pwdata[7:0];
                REG_MIDDLE_DUTY:     cfg_reg.middle_duty        <= pwdata[7:0];
                REG_HIGH_DUTY:       cfg_reg.high_duty          <= pwdata[7:0];
                REG_CHANGE_INTERVAL: cfg_reg.change_interval_ms <= pwdata[15:0];
                REG_REFERENCE_TEMP:  cfg_reg.reference_temp     <= pwdata[15:0];
                REG_DEADBAND:        cfg_reg.deadband           <= pwdata[14:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_INCREASE_TEMP:   prdata = {16'd0, cfg_reg.increase_temp};
            REG_DECREASE_TEMP:   prdata = {16'd0, cfg_reg.decrease_temp};
            REG_LOW_DUTY:        prdata = {24'd0, cfg_reg.low_duty};
            REG_MIDDLE_DUTY:     prdata = {24'd0, cfg_reg.middle_duty};
            REG_HIGH_DUTY:       prdata = {24'd0, cfg_reg.high_duty};
            REG_CHANGE_INTERVAL: prdata = {16'd0, cfg_reg.change_interval_ms};
            REG_REFERENCE_TEMP:  prdata = {16'd0, cfg_reg.reference_temp};
            REG_DEADBAND:        prdata = {17'd0, cfg_reg.deadband};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/flc_step.sv -----
// Control state and the per-item step logic (auto, low-power, manual).
module flc_step
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  flc_pkg::item_t   item,
    input  flc_pkg::cfg_t    cfg,
    output flc_pkg::result_t res
);
    import flc_pkg::*;

    // Control state
    logic [1:0]  stored_level_reg, stored_level_next;
    logic [2:0]  dwell_armed_reg, dwell_armed_next;
    logic [31:0] dwell_start_reg [0:2];
    logic [31:0] dwell_start_next [0:2];
    logic        auto_armed_reg, auto_armed_next;
    logic [31:0] auto_time_reg, auto_time_next;
    logic        lp_armed_reg, lp_armed_next;
    logic [31:0] lp_time_reg, lp_time_next;
    logic        power_reg, power_next;
    logic        off_pending_reg, off_pending_next;
    logic [31:0] off_start_reg, off_start_next;
    logic [7:0]  duty_reg, duty_next;

    // Step decisions
    logic               pwr_now, pend_now;
    zone_t              zone;
    logic               fire;
    logic [1:0]         auto_lvl, lp_lvl;
    logic [1:0]         lvl_up, lvl_hold, lvl_down;
    logic               auto_blocked, lp_blocked;
    logic signed [17:0] err, db_s;
    logic               do_drive;
    logic [1:0]         drive_lvl;
    logic [31:0]        interval;

    assign interval = {16'd0, cfg.change_interval_ms};
    assign lvl_up   = (stored_level_reg == 2'd3) ? 2'd3 : stored_level_reg + 2'd1;
    assign lvl_hold = (stored_level_reg == 2'd0) ? 2'd1 : stored_level_reg;
    assign lvl_down = (stored_level_reg <= 2'd1) ? 2'd1 : stored_level_reg - 2'd1;
    assign err      = $signed({2'b00, item.measured_temp})
                    - $signed({2'b00, cfg.reference_temp});
    assign db_s     = $signed({3'b000, cfg.deadband});

    // Zone of the outlet temperature and its dwell timer
    always_comb
    begin
        if (item.outlet_temp > cfg.increase_temp)
            zone = ZONE_UP;
        else if (item.outlet_temp > cfg.decrease_temp)
            zone = ZONE_HOLD;
        else
            zone = ZONE_DOWN;
        fire = dwell_armed_reg[zone]
            && ((item.now_ms - dwell_start_reg[zone]) >= DWELL_MS);
    end

    // Target level of an auto step
    always_comb
    begin
        case (item.fan_state)
            FAN_INIT:
            begin
                if (item.ambient_temp >= INIT_HIGH_AMBIENT)
                    auto_lvl = 2'd3;
                else if (item.ambient_temp >= INIT_MID_AMBIENT)
                    auto_lvl = 2'd2;
                else
                    auto_lvl = 2'd1;
            end
            FAN_RUN:
            begin
                if (!fire)
                    auto_lvl = stored_level_reg;
                else if (zone == ZONE_UP)
                    auto_lvl = lvl_up;
                else if (zone == ZONE_HOLD)
                    auto_lvl = lvl_hold;
                else
                    auto_lvl = lvl_down;
            end
            default: auto_lvl = 2'd0;
        endcase
    end

    // Target level of a low-power step (deadband around the reference)
    always_comb
    begin
        case (item.fan_state)
            FAN_INIT: lp_lvl = 2'd3;
            FAN_RUN:
            begin
                if (err > db_s)
                    lp_lvl = 2'd3;
                else if (err < -db_s)
                    lp_lvl = 2'd0;
                else
                    lp_lvl = 2'd2;
            end
            default: lp_lvl = 2'd0;
        endcase
    end

    assign auto_blocked = (item.fan_state == FAN_INIT || item.fan_state == FAN_RUN)
                       && auto_armed_reg && ((item.now_ms - auto_time_reg) < interval);
    assign lp_blocked   = (item.fan_state == FAN_RUN) && lp_armed_reg
                       && ((item.now_ms - lp_time_reg) < interval);

    // Next state of one step
    always_comb
    begin
        // power-off timer runs out first
        pwr_now  = power_reg;
        pend_now = off_pending_reg;
        if (off_pending_reg && ((item.now_ms - off_start_reg) >= OFF_DELAY_MS))
        begin
            pwr_now  = 1'b0;
            pend_now = 1'b0;
        end

        stored_level_next = stored_level_reg;
        dwell_armed_next  = dwell_armed_reg;
        for (int k = 0; k < 3; k++)
            dwell_start_next[k] = dwell_start_reg[k];
        auto_armed_next   = auto_armed_reg;
        auto_time_next    = auto_time_reg;
        lp_armed_next     = lp_armed_reg;
        lp_time_next      = lp_time_reg;
        power_next        = pwr_now;
        off_pending_next  = pend_now;
        off_start_next    = off_start_reg;
        duty_next         = duty_reg;
        do_drive          = 1'b0;
        drive_lvl         = 2'd0;

        case (cmd_t'(item.cmd))
            CMD_AUTO:
            begin
                if (item.fan_state == FAN_RUN)
                begin
                    dwell_armed_next = 3'b000;
                    dwell_armed_next[zone] = !fire;
                    if (!dwell_armed_reg[zone])
                        dwell_start_next[zone] = item.now_ms;
                end
                else if (item.fan_state != FAN_INIT)
                begin
                    dwell_armed_next = 3'b000;
                end
                if (!auto_blocked)
                begin
                    do_drive  = 1'b1;
                    drive_lvl = auto_lvl;
                    if (auto_lvl != stored_level_reg)
                    begin
                        stored_level_next = auto_lvl;
                        auto_armed_next   = 1'b1;
                        auto_time_next    = item.now_ms;
                    end
                end
            end
            CMD_LOWPOWER:
            begin
                if (!lp_blocked && (lp_lvl != stored_level_reg))
                begin
                    do_drive          = 1'b1;
                    drive_lvl         = lp_lvl;
                    stored_level_next = lp_lvl;
                    lp_armed_next     = 1'b1;
                    lp_time_next      = item.now_ms;
                end
            end
            CMD_MANUAL:
            begin
                do_drive          = 1'b1;
                drive_lvl         = item.manual_level;
                stored_level_next = item.manual_level;
            end
            default: ;
        endcase

        // drive a level: latch duty, handle power
        if (do_drive)
        begin
            duty_next = duty_of(drive_lvl, cfg);
            if (drive_lvl == 2'd0)
            begin
                if (!pend_now && pwr_now)
                begin
                    off_pending_next = 1'b1;
                    off_start_next   = item.now_ms;
                end
            end
            else
            begin
                power_next       = 1'b1;
                off_pending_next = 1'b0;
            end
        end
    end

    // Result of the step
    assign res.fan_level     = stored_level_next;
    assign res.pwm_duty      = duty_next;
    assign res.power_on      = power_next;
    assign res.level_changed = (stored_level_next != stored_level_reg);

    // State update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_level_reg <= '0;
            dwell_armed_reg  <= '0;
            for (int k = 0; k < 3; k++)
                dwell_start_reg[k] <= '0;
            auto_armed_reg   <= 1'b0;
            auto_time_reg    <= '0;
            lp_armed_reg     <= 1'b0;
            lp_time_reg      <= '0;
            power_reg        <= 1'b0;
            off_pending_reg  <= 1'b0;
            off_start_reg    <= '0;
            duty_reg         <= '0;
        end
        else if (advance)
        begin
            stored_level_reg <= stored_level_next;
            dwell_armed_reg  <= dwell_armed_next;
            for (int k = 0; k < 3; k++)
                dwell_start_reg[k] <= dwell_start_next[k];
            auto_armed_reg   <= auto_armed_next;
            auto_time_reg    <= auto_time_next;
            lp_armed_reg     <= lp_armed_next;
            lp_time_reg      <= lp_time_next;
            power_reg        <= power_next;
            off_pending_reg  <= off_pending_next;
            off_start_reg    <= off_start_next;
            duty_reg         <= duty_next;
        end
    end

endmodule
